// ===== src/tgr_pkg.sv =====
// Shared types and constants for the text glyph rasterizer.
// Used by the serializer and the top level; depends on nothing.
package tgr_pkg;

  localparam int LINE_W    = 14;
  localparam int COLOFS_W  = 13;
  localparam int SUM_W     = 27;
  localparam int PIX_OUT_W = 22;
  localparam int PADDR_W   = 5;
  localparam int FSUM_W    = 17;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_DRAW  = 1'b1;

  localparam logic [2:0] REG_LINE_PITCH  = 3'd0;
  localparam logic [2:0] REG_CELL_WIDTH  = 3'd1;
  localparam logic [2:0] REG_CELL_HEIGHT = 3'd2;
  localparam logic [2:0] REG_TEXT_COLS   = 3'd3;
  localparam logic [2:0] REG_TEXT_ROWS   = 3'd4;
  localparam logic [2:0] REG_BASE_LOW    = 3'd5;
  localparam logic [2:0] REG_BASE_HIGH   = 3'd6;
  localparam logic [2:0] REG_LINE_GFX    = 3'd7;

  localparam logic [11:0] LINE_PITCH_RST  = 12'd720;
  localparam logic [4:0]  CELL_WIDTH_RST  = 5'd9;
  localparam logic [5:0]  CELL_HEIGHT_RST = 6'd16;
  localparam logic [7:0]  TEXT_COLS_RST   = 8'd80;
  localparam logic [7:0]  TEXT_ROWS_RST   = 8'd25;

  localparam logic [4:0] CELL_WIDE_MIN = 5'd9;
  localparam logic [3:0] LAST_NARROW   = 4'd7;
  localparam logic [3:0] LAST_WIDE     = 4'd8;
  localparam logic [1:0] LINE_GFX_CODE = 2'b11;

  typedef struct packed {
    logic [LINE_W-1:0]   line_idx;
    logic [COLOFS_W-1:0] col_ofs;
    logic [3:0]          fg;
    logic [3:0]          bg;
    logic                gfx;
    logic                wide;
  } draw_t;

endpackage

// ===== src/tgr_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module tgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/tgr_serial.sv =====
// Pixel serializer: forms row address; one pixel word per cycle unless stalled.
// Depends on tgr_pkg.
module tgr_serial #(
  parameter int KW = 22
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load_valid,
  input  tgr_pkg::draw_t                     draw,
  input  logic [7:0]                         glyph,
  input  logic [11:0]                        line_pitch,
  output logic                               load_ready,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tgr_pkg::PIX_OUT_W-1:0]      pixel_address,
  output logic [3:0]                         pixel_color,
  output logic                               last_pixel
);
  import tgr_pkg::*;

  logic           busy;
  logic [3:0]     cnt;
  logic [KW-1:0]  pix_addr;
  logic [7:0]     bits;
  logic [3:0]     fg;
  logic [3:0]     bg;
  logic [3:0]     c9;
  logic           wide;
  logic [SUM_W-1:0] sum;
  logic [2:0]     bit_idx;
  logic           done;

  assign sum = SUM_W'(line_pitch) * SUM_W'(draw.line_idx) + SUM_W'(draw.col_ofs);

  assign last_pixel = wide ? (cnt == LAST_WIDE) : (cnt == LAST_NARROW);
  assign done       = busy && !out_stall && last_pixel;
  assign load_ready = !busy || done;
  assign out_valid  = busy;

  assign bit_idx       = LAST_NARROW[2:0] - cnt[2:0];
  assign pixel_color   = (cnt == LAST_WIDE) ? c9 : (bits[bit_idx] ? fg : bg);
  assign pixel_address = PIX_OUT_W'(pix_addr);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load_ready) begin
      busy <= load_valid;
      cnt  <= '0;
    end else if (!out_stall) begin
      cnt <= cnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      pix_addr <= sum[KW-1:0];
      bits     <= glyph;
      fg       <= draw.fg;
      bg       <= draw.bg;
      c9       <= (draw.gfx && glyph[0]) ? draw.fg : draw.bg;
      wide     <= draw.wide;
    end else if (busy && !out_stall) begin
      pix_addr <= pix_addr + KW'(1);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt <= (wide ? LAST_WIDE : LAST_NARROW)))
    else $error("pixel count past end of glyph row");

  a_addr_step: assert property (@(posedge clk) disable iff (rst)
    busy && !out_stall && !last_pixel |=> pix_addr == $past(pix_addr) + KW'(1))
    else $error("pixel address did not advance by one");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    done && !load_valid |=> !busy)
    else $error("serializer stayed busy after last pixel");

endmodule

// ===== src/text_glyph_rasterizer.sv =====
// Text glyph rasterizer top level: configuration registers, font store, fetch stage.
// A draw word passes through the registered fetch stage (font read, draw fields) and
// the serializer registers, then gives one pixel per cycle while out_stall is low,
// 8 or 9 pixels per draw word; a new word is taken while the previous one drains.
// Reset loads register defaults and empties the pipeline; the font store is not cleared.
// Depends on tgr_pkg, tgr_ram and tgr_serial.
module text_glyph_rasterizer #(
  parameter int FONT_ADDR_BITS  = 16,
  parameter int PIXEL_ADDR_BITS = 22
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tgr_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               func,
  input  logic [15:0]                        font_addr,
  input  logic [7:0]                         font_byte,
  input  logic [7:0]                         char_code,
  input  logic [7:0]                         attr,
  input  logic [7:0]                         col,
  input  logic [7:0]                         row,
  input  logic [4:0]                         glyph_row,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tgr_pkg::PIX_OUT_W-1:0]      pixel_address,
  output logic [3:0]                         pixel_color,
  output logic                               last_pixel
);
  import tgr_pkg::*;

  localparam int KW = (PIXEL_ADDR_BITS < PIX_OUT_W) ? PIXEL_ADDR_BITS : PIX_OUT_W;

  logic [11:0] line_pitch;
  logic [4:0]  cell_width;
  logic [5:0]  cell_height;
  logic [7:0]  text_cols;
  logic [7:0]  text_rows;
  logic [15:0] font_base_low;
  logic [15:0] font_base_high;
  logic        line_gfx_enable;

  logic [2:0]  reg_idx;
  logic        cfg_we;

  logic              accept;
  logic              clip;
  logic              valid1;
  draw_t             draw1;
  logic              ser_ready;
  logic [15:0]       base;
  logic [FSUM_W-1:0] fsum;
  logic [7:0]        glyph;
  logic              ram_we;
  logic              ram_re;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_pitch      <= LINE_PITCH_RST;
      cell_width      <= CELL_WIDTH_RST;
      cell_height     <= CELL_HEIGHT_RST;
      text_cols       <= TEXT_COLS_RST;
      text_rows       <= TEXT_ROWS_RST;
      font_base_low   <= '0;
      font_base_high  <= '0;
      line_gfx_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_LINE_PITCH:  line_pitch      <= pwdata[11:0];
        REG_CELL_WIDTH:  cell_width      <= pwdata[4:0];
        REG_CELL_HEIGHT: cell_height     <= pwdata[5:0];
        REG_TEXT_COLS:   text_cols       <= pwdata[7:0];
        REG_TEXT_ROWS:   text_rows       <= pwdata[7:0];
        REG_BASE_LOW:    font_base_low   <= pwdata[15:0];
        REG_BASE_HIGH:   font_base_high  <= pwdata[15:0];
        REG_LINE_GFX:    line_gfx_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LINE_PITCH:  prdata = 32'(line_pitch);
      REG_CELL_WIDTH:  prdata = 32'(cell_width);
      REG_CELL_HEIGHT: prdata = 32'(cell_height);
      REG_TEXT_COLS:   prdata = 32'(text_cols);
      REG_TEXT_ROWS:   prdata = 32'(text_rows);
      REG_BASE_LOW:    prdata = 32'(font_base_low);
      REG_BASE_HIGH:   prdata = 32'(font_base_high);
      REG_LINE_GFX:    prdata = 32'(line_gfx_enable);
      default:         prdata = '0;
    endcase
  end

  assign in_stall = valid1 && !ser_ready;
  assign accept   = in_valid && !in_stall;
  assign ram_we   = accept && (func == FUNC_WRITE);
  assign ram_re   = accept && (func == FUNC_DRAW);

  assign clip = (row >= text_rows) || (col >= text_cols) ||
                ({1'b0, glyph_row} >= cell_height);
  assign base = attr[3] ? font_base_high : font_base_low;
  assign fsum = FSUM_W'(base) + FSUM_W'({char_code, 5'b0}) + FSUM_W'(glyph_row);

  tgr_ram #(
    .WIDTH (8),
    .DEPTH (1 << FONT_ADDR_BITS)
  ) u_font (
    .clk   (clk),
    .we    (ram_we),
    .waddr (font_addr[FONT_ADDR_BITS-1:0]),
    .wdata (font_byte),
    .re    (ram_re),
    .raddr (fsum[FONT_ADDR_BITS-1:0]),
    .rdata (glyph)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (!in_stall) begin
      valid1 <= accept && (func == FUNC_DRAW) && !clip;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      draw1.line_idx <= LINE_W'(row) * LINE_W'(cell_height) + LINE_W'(glyph_row);
      draw1.col_ofs  <= COLOFS_W'(col) * COLOFS_W'(cell_width);
      draw1.fg       <= attr[3:0];
      draw1.bg       <= attr[7:4];
      draw1.gfx      <= line_gfx_enable && (char_code[7:6] == LINE_GFX_CODE);
      draw1.wide     <= cell_width >= CELL_WIDE_MIN;
    end
  end

  tgr_serial #(
    .KW (KW)
  ) u_serial (
    .clk           (clk),
    .rst           (rst),
    .load_valid    (valid1),
    .draw          (draw1),
    .glyph         (glyph),
    .line_pitch    (line_pitch),
    .load_ready    (ser_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .last_pixel    (last_pixel)
  );

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> valid1)
    else $error("input stalled with empty fetch stage");

  a_fetch_hold: assert property (@(posedge clk) disable iff (rst)
    valid1 && in_stall |=> valid1 && $stable(draw1) && $stable(glyph))
    else $error("fetch stage changed while blocked");

  a_handoff: assert property (@(posedge clk) disable iff (rst)
    valid1 && ser_ready |=> out_valid)
    else $error("draw word lost at serializer handoff");

endmodule
